FILE: src/lsef_pkg.sv
package lsef_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W  = 10;
    localparam int ROW_W  = 10;
    localparam int DIM_W  = 11;
    localparam int SIDE_W = 11;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 2;

    typedef enum logic [IDX_W-1:0] {
        CFG_GRID_WIDTH    = 2'd0,
        CFG_GRID_HEIGHT   = 2'd1,
        CFG_OBSTACLE_CHAR = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             obstacle;
        logic             row_end;
        logic             last;
    } cell_ctl_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

FILE: src/largest_empty_square_finder_top.sv
// Largest empty square finder.
//
// Input channel: one cell byte per word (cell_char) with in_valid / in_stall,
// row-major order. Output channel: one word per grid (square_col, square_row,
// square_size) with out_valid / out_stall, given after the grid's last cell.
// Configuration: cfg_we, cfg_index, cfg_wdata; index 0 sets the grid width,
// 1 the height, 2 the obstacle byte. A value of 0 acts as 1 and values
// above 1024 act as 1024.
//
// Throughput is one cell per cycle while in_stall is low. Each cell reads the row
// buffer (a 1024 x 11 single-port-read RAM with registered output) on acceptance
// and writes its side back as it leaves stage 1; a same-column read and write in
// one cycle, as in one-column grids, is forwarded. out_valid is registered and
// rises once the grid's last cell has left stage 1.
//
// Reset clears the counters, neighbour sides and best square; the row buffer
// needs no clearing since row 0 ignores what it reads. While a result waits under
// out_stall, cells keep flowing until the next grid's last cell, which then
// holds in_stall high until the waiting result is taken.
module largest_empty_square_finder_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lsef_pkg::IDX_W-1:0]  cfg_index,
    input  logic [lsef_pkg::DIM_W-1:0]  cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lsef_pkg::CHAR_W-1:0] cell_char,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lsef_pkg::COL_W-1:0]  square_col,
    output logic [lsef_pkg::ROW_W-1:0]  square_row,
    output logic [lsef_pkg::SIDE_W-1:0] square_size
);

    import lsef_pkg::*;

    logic [DIM_W-1:0]  grid_width_reg;
    logic [DIM_W-1:0]  grid_height_reg;
    logic [CHAR_W-1:0] obstacle_char_reg;

    logic [COL_W-1:0]  col_count_reg, col_count_next;
    logic [ROW_W-1:0]  row_count_reg, row_count_next;

    logic              s1_valid_reg, s1_valid_next;
    cell_ctl_t         s1_reg, s1_next;
    logic              fwd_valid_reg, fwd_valid_next;
    logic [SIDE_W-1:0] fwd_data_reg;

    logic [SIDE_W-1:0] left_reg, left_next;
    logic [SIDE_W-1:0] diag_reg, diag_next;
    logic [COL_W-1:0]  best_col_reg, best_col_next;
    logic [ROW_W-1:0]  best_row_reg, best_row_next;
    logic [SIDE_W-1:0] best_side_reg, best_side_next;

    logic              out_valid_reg, out_valid_next;
    logic [COL_W-1:0]  square_col_reg;
    logic [ROW_W-1:0]  square_row_reg;
    logic [SIDE_W-1:0] square_size_reg;

    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [DIM_W-1:0]  col_inc, row_inc;
    logic              row_end, grid_end;
    logic              advance, in_accept, s1_fire, result_fire;
    logic [SIDE_W-1:0] ram_rdata;
    logic [SIDE_W-1:0] up, left, diag, min_lu, min3, side;
    logic [DIM_W-1:0]  col1, row1;
    logic              better;

    assign w_eff = clamp_dim(grid_width_reg, DIM_W'(MAX_WIDTH));
    assign h_eff = clamp_dim(grid_height_reg, DIM_W'(MAX_HEIGHT));

    assign result_fire = s1_valid_reg && s1_reg.last;
    assign advance     = !(result_fire && out_valid_reg && out_stall);
    assign in_stall    = !advance;
    assign in_accept   = in_valid && advance;
    assign s1_fire     = s1_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg    <= DIM_W'(1);
            grid_height_reg   <= DIM_W'(1);
            obstacle_char_reg <= CHAR_W'(111);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:    grid_width_reg    <= cfg_wdata;
                CFG_GRID_HEIGHT:   grid_height_reg   <= cfg_wdata;
                CFG_OBSTACLE_CHAR: obstacle_char_reg <= cfg_wdata[CHAR_W-1:0];
                default:           ;
            endcase
        end
    end

    // stage 0: count position, issue row buffer read
    assign col_inc  = {1'b0, col_count_reg} + DIM_W'(1);
    assign row_inc  = {1'b0, row_count_reg} + DIM_W'(1);
    assign row_end  = col_inc >= w_eff;
    assign grid_end = row_end && (row_inc >= h_eff);

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        s1_valid_next  = s1_valid_reg;
        s1_next        = s1_reg;
        fwd_valid_next = fwd_valid_reg;
        if (advance)
        begin
            s1_valid_next  = in_valid;
            fwd_valid_next = in_valid && s1_valid_reg && (s1_reg.col == col_count_reg);
            if (in_valid)
            begin
                s1_next.col      = col_count_reg;
                s1_next.row      = row_count_reg;
                s1_next.obstacle = (cell_char == obstacle_char_reg);
                s1_next.row_end  = row_end;
                s1_next.last     = grid_end;
                if (grid_end)
                begin
                    col_count_next = '0;
                    row_count_next = '0;
                end
                else if (row_end)
                begin
                    col_count_next = '0;
                    row_count_next = row_inc[ROW_W-1:0];
                end
                else
                begin
                    col_count_next = col_inc[COL_W-1:0];
                end
            end
        end
    end

    lsef_ram #(
        .WIDTH (SIDE_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_buf (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_reg.col),
        .wdata (side),
        .re    (in_accept),
        .raddr (col_count_reg),
        .rdata (ram_rdata)
    );

    // stage 1: side of the square ending here, best square, write back
    assign up     = (s1_reg.row != '0) ? (fwd_valid_reg ? fwd_data_reg : ram_rdata) : '0;
    assign left   = (s1_reg.col != '0) ? left_reg : '0;
    assign diag   = ((s1_reg.col != '0) && (s1_reg.row != '0)) ? diag_reg : '0;
    assign min_lu = (left < up) ? left : up;
    assign min3   = (min_lu < diag) ? min_lu : diag;
    assign side   = s1_reg.obstacle ? '0 : min3 + SIDE_W'(1);
    assign col1   = {1'b0, s1_reg.col} + DIM_W'(1);
    assign row1   = {1'b0, s1_reg.row} + DIM_W'(1);
    assign better = (side > best_side_reg) && (side <= col1) && (side <= row1);

    always_comb
    begin
        left_next      = left_reg;
        diag_next      = diag_reg;
        best_col_next  = best_col_reg;
        best_row_next  = best_row_reg;
        best_side_next = best_side_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (s1_fire)
        begin
            left_next = side;
            diag_next = up;
            if (better)
            begin
                best_side_next = side;
                best_col_next  = COL_W'(col1 - side);
                best_row_next  = ROW_W'(row1 - side);
            end
            if (s1_reg.row_end)
            begin
                left_next = '0;
                diag_next = '0;
            end
            if (s1_reg.last)
            begin
                out_valid_next = 1'b1;
                best_side_next = '0;
                best_col_next  = '0;
                best_row_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            left_reg      <= '0;
            diag_reg      <= '0;
            best_col_reg  <= '0;
            best_row_reg  <= '0;
            best_side_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            best_col_reg  <= best_col_next;
            best_row_reg  <= best_row_next;
            best_side_reg <= best_side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        if (advance)
        begin
            fwd_data_reg <= side;
        end
        if (s1_fire && s1_reg.last)
        begin
            square_col_reg  <= better ? COL_W'(col1 - side) : best_col_reg;
            square_row_reg  <= better ? ROW_W'(row1 - side) : best_row_reg;
            square_size_reg <= better ? side : best_side_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign square_col  = square_col_reg;
    assign square_row  = square_row_reg;
    assign square_size = square_size_reg;

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.last |-> s1_reg.row_end)
        else $error("grid end without row end");

    a_best_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_reg.last |=> (best_side_reg == '0) && out_valid_reg)
        else $error("best square not cleared at grid end");

    a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_fire && out_valid_reg && out_stall |=> s1_valid_reg && $stable(square_size_reg))
        else $error("pending result lost");

    a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg && (s1_reg.col == $past(s1_reg.col)))
        else $error("forward without matching column");

endmodule

FILE: src/lsef_ram.sv
module lsef_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sim/lsef_square_checker.sv
`timescale 1ns / 100ps

module lsef_square_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lsef_pkg::IDX_W-1:0]  cfg_index,
    input  logic [lsef_pkg::DIM_W-1:0]  cfg_wdata,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [lsef_pkg::CHAR_W-1:0] cell_char,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [lsef_pkg::COL_W-1:0]  square_col,
    input  logic [lsef_pkg::ROW_W-1:0]  square_row,
    input  logic [lsef_pkg::SIDE_W-1:0] square_size,
    output int                          mismatches,
    output int                          squares_outstanding
);

    import lsef_pkg::*;

    localparam logic [CHAR_W-1:0] OBSTACLE_AT_RESET = 8'd111;
    localparam int                REPORT_LIMIT      = 10;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [SIDE_W-1:0] size;
    } square_t;

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [CHAR_W-1:0] obstacle_reg;

    logic [SIDE_W-1:0] upper_sides [MAX_WIDTH];
    logic [SIDE_W-1:0] left_side;
    logic [SIDE_W-1:0] diag_side;
    logic [DIM_W-1:0]  col_cnt;
    logic [DIM_W-1:0]  row_cnt;
    logic [COL_W-1:0]  best_col;
    logic [ROW_W-1:0]  best_row;
    logic [SIDE_W-1:0] best_side;

    square_t expected_squares [$];

    function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        if (v > DIM_W'(MAX_WIDTH))
        begin
            r = DIM_W'(MAX_WIDTH);
        end
        return r;
    endfunction

    function automatic void restart_grid();
        left_side = '0;
        diag_side = '0;
        col_cnt   = '0;
        row_cnt   = '0;
        best_col  = '0;
        best_row  = '0;
        best_side = '0;
    endfunction

    function automatic void scan_cell(input logic [CHAR_W-1:0] c);
        logic [SIDE_W-1:0] up;
        logic [SIDE_W-1:0] left;
        logic [SIDE_W-1:0] diag;
        logic [SIDE_W-1:0] m;
        logic [SIDE_W-1:0] side;
        square_t           s;
        up   = (row_cnt > 0) ? upper_sides[col_cnt[COL_W-1:0]] : '0;
        left = (col_cnt > 0) ? left_side : '0;
        diag = (col_cnt > 0 && row_cnt > 0) ? diag_side : '0;
        m    = (left < up) ? left : up;
        m    = (m < diag) ? m : diag;
        side = (c == obstacle_reg) ? '0 : m + SIDE_W'(1);

        diag_side                       = up;
        left_side                       = side;
        upper_sides[col_cnt[COL_W-1:0]] = side;

        if (side > best_side && side <= col_cnt + 1 && side <= row_cnt + 1)
        begin
            best_side = side;
            best_col  = COL_W'(col_cnt + 1 - side);
            best_row  = ROW_W'(row_cnt + 1 - side);
        end

        col_cnt = col_cnt + DIM_W'(1);
        if (col_cnt >= effective_dim(width_reg))
        begin
            col_cnt   = '0;
            left_side = '0;
            diag_side = '0;
            row_cnt   = row_cnt + DIM_W'(1);
            if (row_cnt >= effective_dim(height_reg))
            begin
                s.col  = best_col;
                s.row  = best_row;
                s.size = best_side;
                expected_squares.push_back(s);
                restart_grid();
            end
        end
    endfunction

    function automatic void flag(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t mismatch: %s", $time, msg);
        end
    endfunction

    always @(posedge clk)
    begin
        square_t got;
        square_t want;
        if (!rst_n)
        begin
            width_reg    = DIM_W'(1);
            height_reg   = DIM_W'(1);
            obstacle_reg = OBSTACLE_AT_RESET;
            restart_grid();
            expected_squares.delete();
            mismatches          = 0;
            squares_outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:    width_reg    = cfg_wdata;
                    CFG_GRID_HEIGHT:   height_reg   = cfg_wdata;
                    CFG_OBSTACLE_CHAR: obstacle_reg = cfg_wdata[CHAR_W-1:0];
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                scan_cell(cell_char);
            end
            if (out_valid && !out_stall)
            begin
                got.col  = square_col;
                got.row  = square_row;
                got.size = square_size;
                if (expected_squares.size() == 0)
                begin
                    flag($sformatf("unexpected word col %0d row %0d size %0d",
                                   got.col, got.row, got.size));
                end
                else
                begin
                    want = expected_squares.pop_front();
                    if (got.col !== want.col)
                    begin
                        flag($sformatf("square_col expected %0d, got %0d",
                                       want.col, got.col));
                    end
                    if (got.row !== want.row)
                    begin
                        flag($sformatf("square_row expected %0d, got %0d",
                                       want.row, got.row));
                    end
                    if (got.size !== want.size)
                    begin
                        flag($sformatf("square_size expected %0d, got %0d",
                                       want.size, got.size));
                    end
                end
            end
            squares_outstanding = expected_squares.size();
        end
    end

endmodule

FILE: sim/tb_largest_empty_square_finder_top.sv
`timescale 1ns / 100ps

module tb_largest_empty_square_finder_top;

    import lsef_pkg::*;

    localparam int RANDOM_CELLS = 370;
    localparam int RANDOM_GRIDS = 12;
    localparam int LONG_HOLD    = 200;
    localparam int QUIET_LIMIT  = 2000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IDX_W-1:0]  cfg_index;
    logic [DIM_W-1:0]  cfg_wdata;
    logic              in_valid;
    logic              in_stall;
    logic [CHAR_W-1:0] cell_char;
    logic              out_valid;
    logic              out_stall;
    logic [COL_W-1:0]  square_col;
    logic [ROW_W-1:0]  square_row;
    logic [SIDE_W-1:0] square_size;

    int mismatches;
    int squares_outstanding;
    int cell_total;
    int grid_total;
    int quiet_cycles;
    bit idle_in;
    bit idle_out;
    bit long_hold_req;

    largest_empty_square_finder_top i_dut (.*);

    lsef_square_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int  n;
        bit  held;
        out_stall = 1'b0;
        held      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            n = idle_out ? $urandom_range(0, 5) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!out_valid);
        end
    end

    task automatic push_cell(input logic [CHAR_W-1:0] v);
        int gap;
        gap = idle_in ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        cell_char <= v;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        cell_total++;
    endtask

    task automatic send_grid(input int cells, input int pct, input logic [CHAR_W-1:0] obs);
        for (int i = 0; i < cells; i++)
        begin
            push_cell(($urandom_range(0, 99) < pct) ? obs : CHAR_W'($urandom_range(0, 255)));
        end
        grid_total++;
    endtask

    // drop valid, wait for every square, then let the write-back finish
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (squares_outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_reg(input cfg_index_t idx, input logic [DIM_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_grid(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic [CHAR_W-1:0] obs);
        set_reg(CFG_GRID_WIDTH, w);
        set_reg(CFG_GRID_HEIGHT, h);
        set_reg(CFG_OBSTACLE_CHAR, DIM_W'(obs));
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return '0;
        end
        if (r <= 2)
        begin
            return DIM_W'($urandom_range(7, 12));
        end
        return DIM_W'($urandom_range(1, 6));
    endfunction

    initial
    begin
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [CHAR_W-1:0] obs;
        int                cells;
        int                pct;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_GRID_WIDTH;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        cell_char     = '0;
        idle_in       = 1'b1;
        idle_out      = 1'b1;
        long_hold_req = 1'b0;
        cell_total    = 0;
        grid_total    = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        push_cell(8'd111);
        push_cell(8'hFF);
        push_cell(8'h00);
        settle();
        set_grid(DIM_W'(3), DIM_W'(3), 8'h00);
        for (int i = 0; i < 9; i++)
        begin
            push_cell((i == 4) ? 8'h00 : 8'h5A);
        end
        settle();
        set_grid(DIM_W'(4), DIM_W'(2), 8'hFF);
        repeat (8) push_cell(8'hFF);
        settle();
        set_grid(DIM_W'(2), DIM_W'(2), 8'h00);
        repeat (4) push_cell(8'h01);

        cell_total = 0;
        grid_total = 0;
        while (cell_total < RANDOM_CELLS || grid_total < RANDOM_GRIDS)
        begin
            settle();
            idle_in = ($urandom_range(0, 3) != 0);
            idle_out <= ($urandom_range(0, 3) != 0);
            w   = pick_dim();
            h   = pick_dim();
            obs = CHAR_W'($urandom_range(0, 255));
            set_grid(w, h, obs);
            cells = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
            repeat ($urandom_range(1, 3))
            begin
                pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 70);
                send_grid(cells, pct, obs);
            end
        end

        // hold the receiver so that waiting squares back up into the cell stream
        settle();
        idle_in = 1'b0;
        long_hold_req <= 1'b1;
        set_grid(DIM_W'(3), DIM_W'(3), 8'h2E);
        repeat (5) send_grid(9, 20, 8'h2E);

        settle();
        repeat (6) @(negedge clk);
        if (mismatches == 0 && squares_outstanding == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: largest_empty_square_finder_top.f
src/lsef_pkg.sv
src/lsef_ram.sv
src/largest_empty_square_finder_top.sv
sim/lsef_square_checker.sv
sim/tb_largest_empty_square_finder_top.sv
